[src/salc_pkg.sv]
`default_nettype none

package salc_pkg;

  // Default geometry handed to the top-level parameters.
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  // Fixed field widths.
  localparam int ADDR_IN_W     = 64;
  localparam int ACTION_W      = 2;
  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 6;
  localparam int CNT_W         = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]        WAYS_RST        = 4'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

[src/salc_row_mem.sv]
`default_nettype none

// One row per set. A row that was never written reads back as not
// initialized, so the caller treats all its ways as empty.
module salc_row_mem #(
  parameter int ROW_W = 8,
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output logic      [ROW_W-1:0] rd_data_o,
  output logic                  rd_init_o,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire logic [ROW_W-1:0] wr_data_i
);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] init_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        init_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= init_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_init_o = rd_init_q;

endmodule

`default_nettype wire

[src/set_assoc_lru_cache_model.sv]
`default_nettype none

// Channel   Direction  Signals
// in        sink       in_valid_i / in_ready_o, action_i, address_i
// out       source     out_valid_o / out_ready_i, hit_o, evicted_o, last_o, *_total_o
// cfg       sink       cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A lookup runs through split, row read, a scan of one way per cycle through the
// shared tag comparator, then row write back. Load and store reopen the input
// after the write back; a modify first runs a second row read, scan and write
// back for the same set. Each set row has a valid flip-flop cleared by reset, so
// no clearing pass is needed. The write back stalls while the output register
// holds a word not yet taken.
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [salc_pkg::ACTION_W-1:0]       action_i,
  input  wire logic [salc_pkg::ADDR_IN_W-1:0]      address_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     hit_o,
  output logic                                     evicted_o,
  output logic                                     last_o,
  output logic [salc_pkg::CNT_W-1:0]               hit_total_o,
  output logic [salc_pkg::CNT_W-1:0]               miss_total_o,
  output logic [salc_pkg::CNT_W-1:0]               eviction_total_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W      = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int SHIFT_W   = $clog2((1 << salc_pkg::OFFSET_BITS_W) + MAX_SET_BITS);

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      rank;
    logic [MAX_WAYS-1:0]                 valid;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_READ,
    S_SCAN,
    S_UPDATE
  } state_e;

  state_e state_q, state_d;

  logic [salc_pkg::SET_BITS_W-1:0]    set_bits_q, set_bits_d;
  logic [salc_pkg::OFFSET_BITS_W-1:0] offset_bits_q, offset_bits_d;
  logic [salc_pkg::WAYS_W-1:0]        ways_q, ways_d;

  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  logic                  two_q, two_d;
  logic [SET_W-1:0]      set_q, set_d;
  logic [ADDR_WIDTH-1:0] tag_q, tag_d;

  logic [WAY_W-1:0]     way_q, way_d;
  logic                 hit_found_q, hit_found_d;
  logic [WAY_W-1:0]     hit_way_q, hit_way_d;
  logic                 empty_found_q, empty_found_d;
  logic [WAY_W-1:0]     empty_way_q, empty_way_d;
  logic                 victim_found_q, victim_found_d;
  logic [WAY_W-1:0]     victim_way_q, victim_way_d;
  logic [WAY_CNT_W-1:0] nvalid_q, nvalid_d;

  logic                         out_valid_q, out_valid_d;
  logic                         hit_q, hit_d;
  logic                         evicted_q, evicted_d;
  logic                         last_q, last_d;
  logic [salc_pkg::CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [salc_pkg::CNT_W-1:0]   miss_cnt_q, miss_cnt_d;
  logic [salc_pkg::CNT_W-1:0]   evict_cnt_q, evict_cnt_d;

  logic [SB_W-1:0]      sb;
  logic [SHIFT_W-1:0]   tag_shift;
  logic [ADDR_WIDTH-1:0] off_shifted;
  logic [ADDR_WIDTH-1:0] tag_calc;
  logic [SET_W-1:0]     set_mask;
  logic [WAY_CNT_W-1:0] ways_eff;
  logic [WAY_W-1:0]     last_way;

  logic             rd_en;
  logic [ROW_W-1:0] rd_data;
  logic             rd_init;
  logic             wr_en;
  row_t             row_rd;
  row_t             row_cur;
  row_t             row_new;

  logic             touch;
  logic [WAY_W-1:0] tgt_way;
  logic             out_free;

  // Effective geometry from the registers.
  always_comb begin
    if (int'(set_bits_q) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits_q);
    end
    if (ways_q == '0) begin
      ways_eff = WAY_CNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      ways_eff = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAY_CNT_W'(ways_q);
    end
    last_way = WAY_W'(ways_eff - WAY_CNT_W'(1));
  end

  // Address split: set index above the offset, tag above the set index.
  always_comb begin
    tag_shift = SHIFT_W'(offset_bits_q) + SHIFT_W'(sb);
    if (int'(offset_bits_q) >= ADDR_WIDTH) begin
      off_shifted = '0;
    end else begin
      off_shifted = addr_q >> offset_bits_q;
    end
    if (int'(tag_shift) >= ADDR_WIDTH) begin
      tag_calc = '0;
    end else begin
      tag_calc = addr_q >> tag_shift;
    end
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sb));
    end
  end

  assign row_rd = row_t'(rd_data);

  always_comb begin
    row_cur = row_rd;
    if (!rd_init) begin
      row_cur.valid = '0;
      row_cur.rank  = '0;
    end
  end

  // Row write back. A hit or an eviction moves the target way to most
  // recent; a fill into an empty way ranks it above all valid ways.
  always_comb begin
    touch   = hit_found_q || !empty_found_q;
    tgt_way = hit_found_q ? hit_way_q : (empty_found_q ? empty_way_q : victim_way_q);
    row_new = row_cur;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (touch && (v != int'(tgt_way)) && (v < int'(ways_eff)) && row_cur.valid[v] &&
          (row_cur.rank[v] > row_cur.rank[tgt_way])) begin
        row_new.rank[v] = row_cur.rank[v] - WAY_W'(1);
      end
    end
    if (touch) begin
      row_new.rank[tgt_way] = WAY_W'(nvalid_q - WAY_CNT_W'(1));
    end else begin
      row_new.rank[tgt_way] = WAY_W'(nvalid_q);
    end
    if (!hit_found_q) begin
      row_new.valid[tgt_way] = 1'b1;
      row_new.tag[tgt_way]   = tag_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    set_bits_d     = set_bits_q;
    offset_bits_d  = offset_bits_q;
    ways_d         = ways_q;
    addr_d         = addr_q;
    two_d          = two_q;
    set_d          = set_q;
    tag_d          = tag_q;
    way_d          = way_q;
    hit_found_d    = hit_found_q;
    hit_way_d      = hit_way_q;
    empty_found_d  = empty_found_q;
    empty_way_d    = empty_way_q;
    victim_found_d = victim_found_q;
    victim_way_d   = victim_way_q;
    nvalid_d       = nvalid_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    hit_d          = hit_q;
    evicted_d      = evicted_q;
    last_d         = last_q;
    hit_cnt_d      = hit_cnt_q;
    miss_cnt_d     = miss_cnt_q;
    evict_cnt_d    = evict_cnt_q;
    rd_en          = 1'b0;
    wr_en          = 1'b0;

    if (cfg_we_i) begin
      case (salc_pkg::cfg_reg_e'(cfg_idx_i))
        salc_pkg::REG_SET_BITS:    set_bits_d    = cfg_data_i[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::REG_OFFSET_BITS: offset_bits_d = cfg_data_i;
        salc_pkg::REG_WAYS:        ways_d        = cfg_data_i[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d = address_i[ADDR_WIDTH-1:0];
          two_d  = (salc_pkg::action_e'(action_i) == salc_pkg::ACT_MODIFY);
          if (salc_pkg::action_e'(action_i) != salc_pkg::ACT_NOP) begin
            state_d = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        set_d   = off_shifted[SET_W-1:0] & set_mask;
        tag_d   = tag_calc;
        state_d = S_READ;
      end
      S_READ: begin
        rd_en          = 1'b1;
        way_d          = '0;
        hit_found_d    = 1'b0;
        empty_found_d  = 1'b0;
        victim_found_d = 1'b0;
        nvalid_d       = '0;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        if (row_cur.valid[way_q]) begin
          nvalid_d = nvalid_q + WAY_CNT_W'(1);
          if (!hit_found_q && (row_cur.tag[way_q] == tag_q)) begin
            hit_found_d = 1'b1;
            hit_way_d   = way_q;
          end
          // Lowest rank wins; among equal ranks the later way wins.
          if (!victim_found_q || (row_cur.rank[way_q] <= row_cur.rank[victim_way_q])) begin
            victim_found_d = 1'b1;
            victim_way_d   = way_q;
          end
        end else begin
          empty_found_d = 1'b1;
          empty_way_d   = way_q;
        end
        if (way_q == last_way) begin
          state_d = S_UPDATE;
        end else begin
          way_d = way_q + WAY_W'(1);
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          wr_en       = 1'b1;
          out_valid_d = 1'b1;
          hit_d       = hit_found_q;
          evicted_d   = !hit_found_q && !empty_found_q;
          last_d      = !two_q;
          if (hit_found_q) begin
            hit_cnt_d = salc_pkg::sat_inc(hit_cnt_q);
          end else begin
            miss_cnt_d = salc_pkg::sat_inc(miss_cnt_q);
            if (!empty_found_q) begin
              evict_cnt_d = salc_pkg::sat_inc(evict_cnt_q);
            end
          end
          if (two_q) begin
            two_d   = 1'b0;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      set_bits_q     <= salc_pkg::SET_BITS_RST;
      offset_bits_q  <= salc_pkg::OFFSET_BITS_RST;
      ways_q         <= salc_pkg::WAYS_RST;
      addr_q         <= '0;
      two_q          <= 1'b0;
      set_q          <= '0;
      tag_q          <= '0;
      way_q          <= '0;
      hit_found_q    <= 1'b0;
      hit_way_q      <= '0;
      empty_found_q  <= 1'b0;
      empty_way_q    <= '0;
      victim_found_q <= 1'b0;
      victim_way_q   <= '0;
      nvalid_q       <= '0;
      out_valid_q    <= 1'b0;
      hit_q          <= 1'b0;
      evicted_q      <= 1'b0;
      last_q         <= 1'b0;
      hit_cnt_q      <= '0;
      miss_cnt_q     <= '0;
      evict_cnt_q    <= '0;
    end else begin
      state_q        <= state_d;
      set_bits_q     <= set_bits_d;
      offset_bits_q  <= offset_bits_d;
      ways_q         <= ways_d;
      addr_q         <= addr_d;
      two_q          <= two_d;
      set_q          <= set_d;
      tag_q          <= tag_d;
      way_q          <= way_d;
      hit_found_q    <= hit_found_d;
      hit_way_q      <= hit_way_d;
      empty_found_q  <= empty_found_d;
      empty_way_q    <= empty_way_d;
      victim_found_q <= victim_found_d;
      victim_way_q   <= victim_way_d;
      nvalid_q       <= nvalid_d;
      out_valid_q    <= out_valid_d;
      hit_q          <= hit_d;
      evicted_q      <= evicted_d;
      last_q         <= last_d;
      hit_cnt_q      <= hit_cnt_d;
      miss_cnt_q     <= miss_cnt_d;
      evict_cnt_q    <= evict_cnt_d;
    end
  end

  salc_row_mem #(
    .ROW_W (ROW_W),
    .DEPTH (NUM_SETS),
    .IDX_W (SET_W)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (set_q),
    .rd_data_o (rd_data),
    .rd_init_o (rd_init),
    .wr_en_i   (wr_en),
    .wr_idx_i  (set_q),
    .wr_data_i (ROW_W'(row_new))
  );

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign evicted_o        = evicted_q;
  assign last_o           = last_q;
  assign hit_total_o      = hit_cnt_q;
  assign miss_total_o     = miss_cnt_q;
  assign eviction_total_o = evict_cnt_q;

endmodule

`default_nettype wire

[src/salc_checker.sv]
`default_nettype none

module salc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic [salc_pkg::ACTION_W-1:0]   action_i,
  input wire logic [salc_pkg::ADDR_IN_W-1:0]  address_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic                            hit_o,
  input wire logic                            evicted_o,
  input wire logic                            last_o,
  input wire logic [salc_pkg::CNT_W-1:0]      hit_total_o,
  input wire logic [salc_pkg::CNT_W-1:0]      miss_total_o,
  input wire logic [salc_pkg::CNT_W-1:0]      eviction_total_o,
  input wire logic                            cfg_we_i
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(hit_o) && $stable(evicted_o) && $stable(last_o) &&
      $stable(hit_total_o) && $stable(miss_total_o) && $stable(eviction_total_o))
    else $error("result word changed while stalled");

  // A waiting input word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(action_i) && $stable(address_i))
    else $error("input word changed while waiting");

  // An access that makes a lookup keeps the input closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (action_i == salc_pkg::ACT_LOAD || action_i == salc_pkg::ACT_STORE ||
     action_i == salc_pkg::ACT_MODIFY) |=> !in_ready_o)
    else $error("input reopened during a lookup");

  // While the first word of a modify is shown, its second lookup is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open before the second lookup of a modify");

  // The user must write registers only while the block is idle and no access is offered; the block does not enforce it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> in_ready_o && !in_valid_i)
    else $error("register written while an access was in flight");

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (.*);

`default_nettype wire
